// File: rtl/core/vgalarm_pkg.sv
`default_nettype none

package vgalarm_pkg;

  // Fixed field widths.
  localparam int TEMP_W     = 16;
  localparam int COUNT_W    = 5;
  localparam int COOLDOWN_W = 22;
  localparam int AGE_W      = 20;
  localparam int PATTERN_W  = 16;
  localparam int PHASE_W    = 10;

  // The window sum holds up to 64 differences of 16 bits.
  localparam int SUM_W = 22;

  // Configuration port geometry.
  localparam int CFG_DATA_W = 32;
  localparam int CFG_ADDR_W = 5;

  // Sensor ages stop here.
  localparam logic [AGE_W-1:0] AGE_MAX = '1;

  // Register reset values.
  localparam logic signed [TEMP_W-1:0] INSIDE_LIMIT_RST   = 16'sd2500;
  localparam logic signed [TEMP_W-1:0] GRADIENT_LIMIT_RST = 16'sd200;
  localparam logic [COOLDOWN_W-1:0]    COOLDOWN_RST       = 22'd3600000;
  localparam logic [AGE_W-1:0]         STALE_RST          = 20'd600000;
  localparam logic [PATTERN_W-1:0]     ALARM_PATTERN_RST  = 16'd10000;
  localparam logic [PATTERN_W-1:0]     TEST_PATTERN_RST   = 16'd1000;
  localparam logic [PHASE_W-1:0]       BEEP_PHASE_RST     = 10'd200;

  // Input word operations.
  typedef enum logic [1:0] {
    FUNC_REPORT = 2'd0,
    FUNC_SAMPLE = 2'd1,
    FUNC_TICK   = 2'd2,
    FUNC_TEST   = 2'd3
  } func_t;

  // Register indexes on the configuration port.
  typedef enum logic [2:0] {
    REG_ALARM_ENABLE     = 3'd0,
    REG_INSIDE_LIMIT     = 3'd1,
    REG_GRADIENT_LIMIT   = 3'd2,
    REG_COOLDOWN_MS      = 3'd3,
    REG_STALE_MS         = 3'd4,
    REG_ALARM_PATTERN_MS = 3'd5,
    REG_TEST_PATTERN_MS  = 3'd6,
    REG_BEEP_PHASE_MS    = 3'd7
  } reg_idx_t;

  typedef struct packed {
    logic [1:0]               func;
    logic                     slot;
    logic signed [TEMP_W-1:0] temperature;
  } in_item_t;

  typedef struct packed {
    logic                     buzzer_on;
    logic                     alarm_fired;
    logic signed [TEMP_W-1:0] average_difference;
    logic [COUNT_W-1:0]       window_count;
    logic                     sensors_seen;
    logic                     outside_hotter;
    logic                     sensor_missing;
  } out_item_t;

endpackage

`default_nettype wire

// File: rtl/core/ventilation_gradient_alarm_unit.sv
// Ventilation gradient alarm. Each input word is a temperature report, a sample
// strobe, a millisecond tick or a buzzer test, and each one produces exactly one
// result word. A report, a tick or a test goes from acceptance straight to the
// ST_OUT state, which loads its registered result. A sample strobe with both
// sensors seen passes through ST_ACC to update the difference window and its
// running sum, ST_DIV for the bit-serial divider that averages the window (one
// quotient bit per cycle, one step per bit of the 22-bit sum), ST_CHK for the
// alarm decision and ST_OUT to load the result; a sample before both sensors
// reported goes straight to ST_OUT, like a report. No new word is taken until
// the result of the last one is loaded.
// in_stall stays high while a word is in progress and while the result register
// is still held by out_stall. The window lives in a WINDOW_DEPTH-entry memory
// that needs no clearing pass, since an entry is read back only once written.
`default_nettype none

module ventilation_gradient_alarm_unit #(
  parameter int WINDOW_DEPTH = 20
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  // Input channel
  input  wire logic                               in_valid,
  output logic                                    in_stall,
  input  wire vgalarm_pkg::in_item_t              in_data,
  // Result channel
  output logic                                    out_valid,
  input  wire logic                               out_stall,
  output vgalarm_pkg::out_item_t                  out_data,
  // Configuration port
  input  wire logic                               psel,
  input  wire logic                               penable,
  input  wire logic                               pwrite,
  input  wire logic [vgalarm_pkg::CFG_ADDR_W-1:0] paddr,
  input  wire logic [vgalarm_pkg::CFG_DATA_W-1:0] pwdata,
  output logic      [vgalarm_pkg::CFG_DATA_W-1:0] prdata,
  output logic                                    pready
);

  localparam int WIN_IDX_W = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
  localparam int FILL_W    = $clog2(WINDOW_DEPTH + 1);
  localparam int SUM_W     = vgalarm_pkg::SUM_W;
  localparam int TEMP_W    = vgalarm_pkg::TEMP_W;
  localparam int CNT_W     = $clog2(SUM_W);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ACC,
    ST_DIV,
    ST_CHK,
    ST_OUT
  } state_t;

  // Configuration registers.
  logic                                    alarm_enable_r;
  logic signed [TEMP_W-1:0]                inside_limit_r;
  logic signed [TEMP_W-1:0]                gradient_limit_r;
  logic [vgalarm_pkg::COOLDOWN_W-1:0]      cooldown_ms_r;
  logic [vgalarm_pkg::AGE_W-1:0]           stale_ms_r;
  logic [vgalarm_pkg::PATTERN_W-1:0]       alarm_pattern_r;
  logic [vgalarm_pkg::PATTERN_W-1:0]       test_pattern_r;
  logic [vgalarm_pkg::PHASE_W-1:0]         beep_phase_r;
  logic                                    cfg_we;
  vgalarm_pkg::reg_idx_t                   cfg_idx;

  // Block state and next values.
  state_t                                  state_r, state_nxt;
  logic signed [TEMP_W-1:0]                inside_r, inside_nxt;
  logic signed [TEMP_W-1:0]                outside_r, outside_nxt;
  logic [1:0]                              seen_r, seen_nxt;
  logic [vgalarm_pkg::AGE_W-1:0]           age_r [2];
  logic [vgalarm_pkg::AGE_W-1:0]           age_nxt [2];
  logic [WIN_IDX_W-1:0]                    wr_idx_r, wr_idx_nxt;
  logic [FILL_W-1:0]                       fill_r, fill_nxt;
  logic signed [SUM_W-1:0]                 sum_r, sum_nxt;
  logic signed [TEMP_W-1:0]                avg_r, avg_nxt;
  logic [vgalarm_pkg::COOLDOWN_W-1:0]      cool_r, cool_nxt;
  logic [vgalarm_pkg::PATTERN_W-1:0]       pat_left_r, pat_left_nxt;
  logic [vgalarm_pkg::PHASE_W-1:0]         ph_left_r, ph_left_nxt;
  logic                                    pat_active_r, pat_active_nxt;
  logic                                    buzzer_r, buzzer_nxt;
  logic                                    fired_r, fired_nxt;
  logic signed [TEMP_W-1:0]                diff_r, diff_nxt;
  logic                                    neg_r, neg_nxt;
  logic [SUM_W-1:0]                        quo_r, quo_nxt;
  logic [FILL_W-1:0]                       rem_r, rem_nxt;
  logic [CNT_W-1:0]                        cnt_r, cnt_nxt;
  logic                                    out_valid_r, out_valid_nxt;
  vgalarm_pkg::out_item_t                  out_data_r, out_data_nxt;

  // Window memory.
  logic signed [TEMP_W-1:0]                win_mem [WINDOW_DEPTH];
  logic signed [TEMP_W-1:0]                rd_q_r;
  logic                                    mem_we;
  logic                                    mem_re;

  // Divider step and helpers.
  logic [FILL_W:0]                         rem_shift;
  logic [FILL_W+1:0]                       trial;
  logic [vgalarm_pkg::PHASE_W-1:0]         phase_len;
  logic                                    win_full;
  logic [vgalarm_pkg::PATTERN_W-1:0]       pl_dec;
  logic [vgalarm_pkg::PHASE_W-1:0]         ph_dec;
  logic [TEMP_W-1:0]                       quo_low;
  logic                                    stale_any;

  assign pready   = 1'b1;
  assign cfg_we   = psel && penable && pwrite;
  assign cfg_idx  = vgalarm_pkg::reg_idx_t'(paddr[4:2]);
  assign in_stall = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign phase_len = (beep_phase_r == '0) ? vgalarm_pkg::PHASE_W'(1) : beep_phase_r;
  assign win_full  = (fill_r == FILL_W'(WINDOW_DEPTH));
  assign pl_dec    = (pat_left_r != '0) ? pat_left_r - 1'b1 : pat_left_r;
  assign ph_dec    = (ph_left_r != '0) ? ph_left_r - 1'b1 : ph_left_r;
  assign stale_any = (age_r[0] > stale_ms_r) || (age_r[1] > stale_ms_r);

  // One restoring divide step: shift in the next dividend bit, try the count.
  assign rem_shift = {rem_r, quo_r[SUM_W-1]};
  assign trial     = {1'b0, rem_shift} - {2'b00, fill_r};

  // Register readback.
  always_comb begin
    prdata = '0;
    case (cfg_idx)
      vgalarm_pkg::REG_ALARM_ENABLE:     prdata = 32'(alarm_enable_r);
      vgalarm_pkg::REG_INSIDE_LIMIT:     prdata = 32'($unsigned(inside_limit_r));
      vgalarm_pkg::REG_GRADIENT_LIMIT:   prdata = 32'($unsigned(gradient_limit_r));
      vgalarm_pkg::REG_COOLDOWN_MS:      prdata = 32'(cooldown_ms_r);
      vgalarm_pkg::REG_STALE_MS:         prdata = 32'(stale_ms_r);
      vgalarm_pkg::REG_ALARM_PATTERN_MS: prdata = 32'(alarm_pattern_r);
      vgalarm_pkg::REG_TEST_PATTERN_MS:  prdata = 32'(test_pattern_r);
      vgalarm_pkg::REG_BEEP_PHASE_MS:    prdata = 32'(beep_phase_r);
      default:                           prdata = '0;
    endcase
  end

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      alarm_enable_r   <= 1'b0;
      inside_limit_r   <= vgalarm_pkg::INSIDE_LIMIT_RST;
      gradient_limit_r <= vgalarm_pkg::GRADIENT_LIMIT_RST;
      cooldown_ms_r    <= vgalarm_pkg::COOLDOWN_RST;
      stale_ms_r       <= vgalarm_pkg::STALE_RST;
      alarm_pattern_r  <= vgalarm_pkg::ALARM_PATTERN_RST;
      test_pattern_r   <= vgalarm_pkg::TEST_PATTERN_RST;
      beep_phase_r     <= vgalarm_pkg::BEEP_PHASE_RST;
    end else if (cfg_we) begin
      case (cfg_idx)
        vgalarm_pkg::REG_ALARM_ENABLE:     alarm_enable_r   <= pwdata[0];
        vgalarm_pkg::REG_INSIDE_LIMIT:     inside_limit_r   <= $signed(pwdata[15:0]);
        vgalarm_pkg::REG_GRADIENT_LIMIT:   gradient_limit_r <= $signed(pwdata[15:0]);
        vgalarm_pkg::REG_COOLDOWN_MS:      cooldown_ms_r    <= pwdata[21:0];
        vgalarm_pkg::REG_STALE_MS:         stale_ms_r       <= pwdata[19:0];
        vgalarm_pkg::REG_ALARM_PATTERN_MS: alarm_pattern_r  <= pwdata[15:0];
        vgalarm_pkg::REG_TEST_PATTERN_MS:  test_pattern_r   <= pwdata[15:0];
        vgalarm_pkg::REG_BEEP_PHASE_MS:    beep_phase_r     <= pwdata[9:0];
        default: ;
      endcase
    end
  end

  // Sequencer and datapath next values.
  always_comb begin
    state_nxt      = state_r;
    inside_nxt     = inside_r;
    outside_nxt    = outside_r;
    seen_nxt       = seen_r;
    age_nxt[0]     = age_r[0];
    age_nxt[1]     = age_r[1];
    wr_idx_nxt     = wr_idx_r;
    fill_nxt       = fill_r;
    sum_nxt        = sum_r;
    avg_nxt        = avg_r;
    cool_nxt       = cool_r;
    pat_left_nxt   = pat_left_r;
    ph_left_nxt    = ph_left_r;
    pat_active_nxt = pat_active_r;
    buzzer_nxt     = buzzer_r;
    fired_nxt      = fired_r;
    diff_nxt       = diff_r;
    neg_nxt        = neg_r;
    quo_nxt        = quo_r;
    rem_nxt        = rem_r;
    cnt_nxt        = cnt_r;
    out_valid_nxt  = out_valid_r;
    out_data_nxt   = out_data_r;
    mem_we         = 1'b0;
    mem_re         = 1'b0;
    quo_low        = '0;

    // The result word leaves when the far side takes it.
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          fired_nxt = 1'b0;
          state_nxt = ST_OUT;
          case (vgalarm_pkg::func_t'(in_data.func))
            vgalarm_pkg::FUNC_REPORT: begin
              if (!in_data.slot) begin
                inside_nxt = in_data.temperature;
              end else begin
                outside_nxt = in_data.temperature;
              end
              seen_nxt[in_data.slot] = 1'b1;
              age_nxt[in_data.slot]  = '0;
            end
            vgalarm_pkg::FUNC_SAMPLE: begin
              // Start the window update only once both sensors have reported.
              if (seen_r == 2'b11) begin
                diff_nxt  = inside_r - outside_r;
                mem_re    = 1'b1;
                state_nxt = ST_ACC;
              end
            end
            vgalarm_pkg::FUNC_TICK: begin
              if (age_r[0] != vgalarm_pkg::AGE_MAX) age_nxt[0] = age_r[0] + 1'b1;
              if (age_r[1] != vgalarm_pkg::AGE_MAX) age_nxt[1] = age_r[1] + 1'b1;
              if (cool_r != '0) cool_nxt = cool_r - 1'b1;
              // Beep pattern: at the end of a phase, stop or toggle.
              if (pat_active_r) begin
                pat_left_nxt = pl_dec;
                ph_left_nxt  = ph_dec;
                if (ph_dec == '0) begin
                  if (pl_dec == '0) begin
                    pat_active_nxt = 1'b0;
                    buzzer_nxt     = 1'b0;
                  end else begin
                    buzzer_nxt  = !buzzer_r;
                    ph_left_nxt = phase_len;
                  end
                end
              end
            end
            default: begin
              // Buzzer test keeps a running phase timer.
              pat_left_nxt = test_pattern_r;
              buzzer_nxt   = 1'b1;
              if (!pat_active_r) begin
                ph_left_nxt    = phase_len;
                pat_active_nxt = 1'b1;
              end
            end
          endcase
        end
      end

      ST_ACC: begin
        // Replace the oldest difference once the window is full.
        mem_we  = 1'b1;
        sum_nxt = sum_r + SUM_W'(diff_r);
        if (win_full) begin
          sum_nxt = sum_nxt - SUM_W'(rd_q_r);
        end
        wr_idx_nxt = (wr_idx_r == WIN_IDX_W'(WINDOW_DEPTH - 1)) ? '0 : wr_idx_r + 1'b1;
        if (!win_full) begin
          fill_nxt = fill_r + 1'b1;
        end
        // Divide the magnitude and restore the sign afterwards.
        neg_nxt   = sum_nxt[SUM_W-1];
        quo_nxt   = sum_nxt[SUM_W-1] ? $unsigned(-sum_nxt) : $unsigned(sum_nxt);
        rem_nxt   = '0;
        cnt_nxt   = CNT_W'(SUM_W - 1);
        state_nxt = ST_DIV;
      end

      ST_DIV: begin
        if (!trial[FILL_W+1]) begin
          rem_nxt = trial[FILL_W-1:0];
          quo_nxt = {quo_r[SUM_W-2:0], 1'b1};
        end else begin
          rem_nxt = rem_shift[FILL_W-1:0];
          quo_nxt = {quo_r[SUM_W-2:0], 1'b0};
        end
        if (cnt_r == '0) begin
          quo_low   = quo_nxt[TEMP_W-1:0];
          avg_nxt   = neg_r ? $signed(-quo_low) : $signed(quo_low);
          state_nxt = ST_CHK;
        end else begin
          cnt_nxt = cnt_r - 1'b1;
        end
      end

      ST_CHK: begin
        // Alarm decision, when enabled, on a full, warm, steep window outside cooldown.
        if (alarm_enable_r && win_full && (inside_r > inside_limit_r) &&
            (avg_r > gradient_limit_r) && (cool_r == '0)) begin
          fired_nxt    = 1'b1;
          cool_nxt     = cooldown_ms_r;
          pat_left_nxt = alarm_pattern_r;
          buzzer_nxt   = 1'b1;
          if (!pat_active_r) begin
            ph_left_nxt    = phase_len;
            pat_active_nxt = 1'b1;
          end
        end
        state_nxt = ST_OUT;
      end

      ST_OUT: begin
        // Load the result word once the output register is free.
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt                   = 1'b1;
          out_data_nxt.buzzer_on          = buzzer_r;
          out_data_nxt.alarm_fired        = fired_r;
          out_data_nxt.average_difference = avg_r;
          out_data_nxt.window_count       = vgalarm_pkg::COUNT_W'(fill_r);
          out_data_nxt.sensors_seen       = (seen_r == 2'b11);
          out_data_nxt.outside_hotter     = (seen_r == 2'b11) && (outside_r > inside_r);
          out_data_nxt.sensor_missing     = (seen_r != 2'b11) || stale_any;
          state_nxt                       = ST_IDLE;
        end
      end

      default: state_nxt = ST_IDLE;
    endcase
  end

  // State, working registers and the result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      inside_r     <= '0;
      outside_r    <= '0;
      seen_r       <= '0;
      age_r[0]     <= '0;
      age_r[1]     <= '0;
      wr_idx_r     <= '0;
      fill_r       <= '0;
      sum_r        <= '0;
      avg_r        <= '0;
      cool_r       <= '0;
      pat_left_r   <= '0;
      ph_left_r    <= '0;
      pat_active_r <= 1'b0;
      buzzer_r     <= 1'b0;
      fired_r      <= 1'b0;
      diff_r       <= '0;
      neg_r        <= 1'b0;
      quo_r        <= '0;
      rem_r        <= '0;
      cnt_r        <= '0;
      out_valid_r  <= 1'b0;
      out_data_r   <= '0;
    end else begin
      state_r      <= state_nxt;
      inside_r     <= inside_nxt;
      outside_r    <= outside_nxt;
      seen_r       <= seen_nxt;
      age_r[0]     <= age_nxt[0];
      age_r[1]     <= age_nxt[1];
      wr_idx_r     <= wr_idx_nxt;
      fill_r       <= fill_nxt;
      sum_r        <= sum_nxt;
      avg_r        <= avg_nxt;
      cool_r       <= cool_nxt;
      pat_left_r   <= pat_left_nxt;
      ph_left_r    <= ph_left_nxt;
      pat_active_r <= pat_active_nxt;
      buzzer_r     <= buzzer_nxt;
      fired_r      <= fired_nxt;
      diff_r       <= diff_nxt;
      neg_r        <= neg_nxt;
      quo_r        <= quo_nxt;
      rem_r        <= rem_nxt;
      cnt_r        <= cnt_nxt;
      out_valid_r  <= out_valid_nxt;
      out_data_r   <= out_data_nxt;
    end
  end

  // Window memory: one write and one registered read port.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      win_mem[wr_idx_r] <= diff_r;
    end
    if (mem_re) begin
      rd_q_r <= win_mem[wr_idx_r];
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/vgalarm_checker.sv
`default_nettype none

module vgalarm_checker (
  input wire logic                   clk,
  input wire logic                   rst_n,
  input wire logic                   in_valid,
  input wire logic                   in_stall,
  input wire logic                   out_valid,
  input wire logic                   out_stall,
  input wire vgalarm_pkg::out_item_t out_data
);

  // A result word held back by the far side stays put.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result word changed or dropped");

  // Every accepted word moves the block out of the idle state, so the input closes after acceptance.
  assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input still open right after a word was accepted");

  // Firing the alarm always turns the buzzer on.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.alarm_fired |-> out_data.buzzer_on)
    else $error("alarm fired with the buzzer off");

  // Outside hotter is only reported with both sensors seen.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.outside_hotter |-> out_data.sensors_seen)
    else $error("outside hotter without both sensors");

  // A sensor that never reported counts as missing.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.sensors_seen |-> out_data.sensor_missing)
    else $error("unseen sensor not flagged as missing");

endmodule

bind ventilation_gradient_alarm_unit vgalarm_checker u_vgalarm_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

`default_nettype wire

// File: sim/ventilation_gradient_alarm_checker.sv
module ventilation_gradient_alarm_checker
  import vgalarm_pkg::*;
#(
  parameter int WINDOW_DEPTH = 20
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  input  wire logic                  in_stall,
  input  wire in_item_t              in_data,
  input  wire logic                  out_valid,
  input  wire logic                  out_stall,
  input  wire out_item_t             out_data,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic                  pready,
  input  wire logic [CFG_ADDR_W-1:0] paddr,
  input  wire logic [CFG_DATA_W-1:0] pwdata,
  output int                         expected_left,
  output int                         mismatch_count
);

  // Shadow copy of the register file.
  logic                     alarm_en;
  logic signed [TEMP_W-1:0] lim_in;
  logic signed [TEMP_W-1:0] lim_grad;
  logic [COOLDOWN_W-1:0]    cool_cfg;
  logic [AGE_W-1:0]         stale_cfg;
  logic [PATTERN_W-1:0]     alarm_len;
  logic [PATTERN_W-1:0]     test_len;
  logic [PHASE_W-1:0]       beep_cfg;

  // Predicted sensor, window and buzzer state.
  logic signed [TEMP_W-1:0] t_in;
  logic signed [TEMP_W-1:0] t_out;
  logic [1:0]               seen;
  logic [AGE_W-1:0]         age_ms [2];
  logic signed [TEMP_W-1:0] diffs [WINDOW_DEPTH];
  int                       wr_idx;
  int                       fill;
  int                       win_sum;
  int                       avg_last;
  logic [COOLDOWN_W-1:0]    cool_left;
  logic [PATTERN_W-1:0]     pat_left;
  logic [PHASE_W-1:0]       ph_left;
  logic                     pat_on;
  logic                     buzz;

  // Predicted result words, oldest first.
  out_item_t predicted_words [$];

  // A programmed phase length of zero behaves as one millisecond.
  function automatic logic [PHASE_W-1:0] beep_len();
    return (beep_cfg == '0) ? PHASE_W'(1) : beep_cfg;
  endfunction

  // A restart reloads the time and forces the buzzer on, but a running phase keeps its timer.
  function automatic void start_beeps(logic [PATTERN_W-1:0] len);
    pat_left = len;
    buzz = 1'b1;
    if (!pat_on) begin
      ph_left = beep_len();
      pat_on = 1'b1;
    end
  endfunction

  // Advance the predicted state by one input word and build the result word it yields.
  function automatic out_item_t predict_alarm_word(in_item_t w);
    out_item_t                r;
    logic                     fired;
    logic                     both;
    logic signed [TEMP_W-1:0] d;
    int                       idx;
    int                       s;
    fired = 1'b0;
    case (w.func)
      FUNC_REPORT: begin
        if (w.slot) t_out = w.temperature;
        else t_in = w.temperature;
        seen[w.slot] = 1'b1;
        age_ms[w.slot] = '0;
      end
      FUNC_SAMPLE: begin
        // A sample before both sensors have reported leaves everything as it was.
        if (seen == 2'b11) begin
          d = t_in - t_out;
          idx = (wr_idx >= WINDOW_DEPTH) ? 0 : wr_idx;
          if (fill >= WINDOW_DEPTH) win_sum -= diffs[idx];
          diffs[idx] = d;
          win_sum += d;
          wr_idx = (idx + 1 >= WINDOW_DEPTH) ? 0 : idx + 1;
          if (fill < WINDOW_DEPTH) fill++;
          avg_last = win_sum / fill;
          if (alarm_en && fill >= WINDOW_DEPTH && t_in > lim_in &&
              avg_last > int'(lim_grad) && cool_left == '0) begin
            cool_left = cool_cfg;
            start_beeps(alarm_len);
            fired = 1'b1;
          end
        end
      end
      FUNC_TICK: begin
        for (s = 0; s < 2; s++)
          if (age_ms[s] != AGE_MAX) age_ms[s] = age_ms[s] + 1'b1;
        if (cool_left != '0) cool_left = cool_left - 1'b1;
        if (pat_on) begin
          if (pat_left != '0) pat_left = pat_left - 1'b1;
          if (ph_left != '0) ph_left = ph_left - 1'b1;
          // At the end of a phase the pattern either stops or flips the buzzer.
          if (ph_left == '0) begin
            if (pat_left == '0) begin
              pat_on = 1'b0;
              buzz = 1'b0;
            end else begin
              buzz = ~buzz;
              ph_left = beep_len();
            end
          end
        end
      end
      default: start_beeps(test_len);
    endcase
    both = (seen == 2'b11);
    r.buzzer_on          = buzz;
    r.alarm_fired        = fired;
    r.average_difference = avg_last[TEMP_W-1:0];
    r.window_count       = COUNT_W'(fill);
    r.sensors_seen       = both;
    r.outside_hotter     = both && (t_out > t_in);
    r.sensor_missing     = !both || age_ms[0] > stale_cfg || age_ms[1] > stale_cfg;
    return r;
  endfunction

  task automatic check_field(string name, int want, int got);
    if (want != got) begin
      $error("%s expected %0d got %0d", name, want, got);
      mismatch_count++;
    end
  endtask

  // Watch both channels and the register port on every rising edge.
  always @(posedge clk) begin : watch
    out_item_t want;
    if (!rst_n) begin
      alarm_en  = 1'b0;
      lim_in    = INSIDE_LIMIT_RST;
      lim_grad  = GRADIENT_LIMIT_RST;
      cool_cfg  = COOLDOWN_RST;
      stale_cfg = STALE_RST;
      alarm_len = ALARM_PATTERN_RST;
      test_len  = TEST_PATTERN_RST;
      beep_cfg  = BEEP_PHASE_RST;
      t_in      = '0;
      t_out     = '0;
      seen      = '0;
      age_ms[0] = '0;
      age_ms[1] = '0;
      foreach (diffs[i]) diffs[i] = '0;
      wr_idx    = 0;
      fill      = 0;
      win_sum   = 0;
      avg_last  = 0;
      cool_left = '0;
      pat_left  = '0;
      ph_left   = '0;
      pat_on    = 1'b0;
      buzz      = 1'b0;
      mismatch_count = 0;
      predicted_words.delete();
    end else begin
      // Register writes land at the access edge.
      if (psel && penable && pwrite && pready) begin
        case (paddr[CFG_ADDR_W-1:2])
          REG_ALARM_ENABLE:     alarm_en  = pwdata[0];
          REG_INSIDE_LIMIT:     lim_in    = pwdata[TEMP_W-1:0];
          REG_GRADIENT_LIMIT:   lim_grad  = pwdata[TEMP_W-1:0];
          REG_COOLDOWN_MS:      cool_cfg  = pwdata[COOLDOWN_W-1:0];
          REG_STALE_MS:         stale_cfg = pwdata[AGE_W-1:0];
          REG_ALARM_PATTERN_MS: alarm_len = pwdata[PATTERN_W-1:0];
          REG_TEST_PATTERN_MS:  test_len  = pwdata[PATTERN_W-1:0];
          REG_BEEP_PHASE_MS:    beep_cfg  = pwdata[PHASE_W-1:0];
          default: ;
        endcase
      end
      // Compare an accepted result word against the oldest prediction.
      if (out_valid && !out_stall) begin
        if (predicted_words.size() == 0) begin
          $error("result word arrived with no prediction waiting");
          mismatch_count++;
        end else begin
          want = predicted_words.pop_front();
          check_field("buzzer_on", want.buzzer_on, out_data.buzzer_on);
          check_field("alarm_fired", want.alarm_fired, out_data.alarm_fired);
          check_field("average_difference", want.average_difference,
                      out_data.average_difference);
          check_field("window_count", want.window_count, out_data.window_count);
          check_field("sensors_seen", want.sensors_seen, out_data.sensors_seen);
          check_field("outside_hotter", want.outside_hotter, out_data.outside_hotter);
          check_field("sensor_missing", want.sensor_missing, out_data.sensor_missing);
        end
      end
      if (in_valid && !in_stall) predicted_words.push_back(predict_alarm_word(in_data));
    end
    expected_left <= predicted_words.size();
  end

endmodule

// File: sim/ventilation_gradient_alarm_unit_tb.sv
module ventilation_gradient_alarm_unit_tb;
  import vgalarm_pkg::*;

  localparam int WINDOW_DEPTH = 20;
  localparam int RUN_LIMIT    = 15_000_000;

  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  in_valid  = 1'b0;
  in_item_t              in_data   = '0;
  logic                  out_stall = 1'b0;
  logic                  psel      = 1'b0;
  logic                  penable   = 1'b0;
  logic                  pwrite    = 1'b0;
  logic [CFG_ADDR_W-1:0] paddr     = '0;
  logic [CFG_DATA_W-1:0] pwdata    = '0;

  logic                  in_stall;
  logic                  out_valid;
  out_item_t             out_data;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;
  int                    expected_left;
  int                    mismatch_count;

  // Number of words still to be sent back to back.
  int send_calm = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  ventilation_gradient_alarm_unit #(.WINDOW_DEPTH(WINDOW_DEPTH)) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  ventilation_gradient_alarm_checker #(.WINDOW_DEPTH(WINDOW_DEPTH)) u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_data       (in_data),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_data      (out_data),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .pready        (pready),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .expected_left (expected_left),
    .mismatch_count(mismatch_count)
  );

  // Idle lengths: mostly none or short, now and then a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 15);
    return $urandom_range(40, 150);
  endfunction

  // Offer one word, hold it until accepted, then maybe idle.
  task automatic send_word(in_item_t w);
    int gap;
    in_valid <= 1'b1;
    in_data  <= w;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (send_calm > 0) begin
      send_calm--;
      gap = 0;
    end else begin
      if ($urandom_range(0, 49) == 0) send_calm = $urandom_range(20, 60);
      gap = pick_gap();
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Stop sending and wait until every predicted result word has come back.
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_left != 0) @(posedge clk);
  endtask

  // Setup phase, access phase, then an idle phase on the register port.
  task automatic cfg_write(reg_idx_t idx, logic [CFG_DATA_W-1:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  // The receiver stalls at random, with stretches of no stall at all.
  initial begin : stall_pattern
    int busy;
    int hold;
    int calm;
    calm = 0;
    forever begin
      busy = $urandom_range(1, 6);
      if (calm > 0) calm--;
      else if ($urandom_range(0, 39) == 0) calm = $urandom_range(10, 30);
      repeat (busy) @(posedge clk);
      hold = (calm > 0) ? 0 : pick_gap();
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  initial begin : stimulus
    in_item_t w;
    int ph;
    int k;
    int r;
    int base_in;
    int base_out;
    int spread;
    int c_en, c_lim, c_grad, c_cool, c_stale, c_alarm, c_test, c_beep;

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Directed words under the reset settings.
    // A sample and a tick before any sensor has reported.
    send_word('{FUNC_SAMPLE, 1'b1, 16'h7FFF});
    send_word('{FUNC_TICK, 1'b0, 16'h8000});
    // Buzzer test starts the short pattern.
    send_word('{FUNC_TEST, 1'b1, 16'h5A5A});
    // Only the inside sensor has reported, so the sample changes nothing.
    send_word('{FUNC_REPORT, 1'b0, 16'h7FFF});
    send_word('{FUNC_SAMPLE, 1'b0, 16'h0000});
    // Largest positive difference wraps around to minus one.
    send_word('{FUNC_REPORT, 1'b1, 16'h8000});
    send_word('{FUNC_SAMPLE, 1'b0, 16'hFFFF});
    // Outside hotter, and the most negative difference wraps to plus one.
    send_word('{FUNC_REPORT, 1'b0, 16'h8000});
    send_word('{FUNC_REPORT, 1'b1, 16'h7FFF});
    send_word('{FUNC_SAMPLE, 1'b1, 16'h1234});
    // Equal-ish small readings, including minus one.
    send_word('{FUNC_REPORT, 1'b0, 16'h0000});
    send_word('{FUNC_REPORT, 1'b1, 16'hFFFF});
    send_word('{FUNC_SAMPLE, 1'b0, 16'h0000});
    send_word('{FUNC_TICK, 1'b1, 16'hFFFF});
    send_word('{FUNC_TICK, 1'b0, 16'h0000});
    // Restarting a running pattern keeps the phase timer.
    send_word('{FUNC_TEST, 1'b0, 16'hA5A5});
    send_word('{FUNC_TICK, 1'b1, 16'h0F0F});
    send_word('{FUNC_SAMPLE, 1'b1, 16'hF0F0});

    // Random phases, each under its own register settings.
    for (ph = 0; ph < 10; ph++) begin
      drain_results();
      base_in  = int'($urandom_range(0, 6000)) - 1000;
      base_out = base_in - int'($urandom_range(0, 900)) + 250;
      spread   = $urandom_range(0, 300);
      if (ph == 0) begin
        // Lowest settings: alarms fire whenever allowed, and patterns are empty.
        c_en = 1; c_lim = -32768; c_grad = -32768; c_cool = 0; c_stale = 0;
        c_alarm = 0; c_test = 0; c_beep = 1;
      end else if (ph == 1) begin
        // Highest settings.
        c_en = 1; c_lim = 32767; c_grad = 32767; c_cool = 4194303; c_stale = 1048575;
        c_alarm = 65535; c_test = 65535; c_beep = 1023;
      end else begin
        c_en    = ($urandom_range(0, 3) != 0);
        c_lim   = base_in - int'($urandom_range(0, 400)) + 150;
        c_grad  = (base_in - base_out) - int'($urandom_range(0, 300)) + 80;
        c_cool  = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
        c_stale = $urandom_range(0, 60);
        c_alarm = $urandom_range(0, 40);
        c_test  = $urandom_range(0, 20);
        c_beep  = $urandom_range(0, 6);
        // One phase runs with a zero beep phase and no cooldown.
        if (ph == 2) begin
          c_beep = 0;
          c_cool = 0;
        end
      end
      cfg_write(REG_ALARM_ENABLE, c_en);
      cfg_write(REG_INSIDE_LIMIT, c_lim);
      cfg_write(REG_GRADIENT_LIMIT, c_grad);
      cfg_write(REG_COOLDOWN_MS, c_cool);
      cfg_write(REG_STALE_MS, c_stale);
      cfg_write(REG_ALARM_PATTERN_MS, c_alarm);
      cfg_write(REG_TEST_PATTERN_MS, c_test);
      cfg_write(REG_BEEP_PHASE_MS, c_beep);

      for (k = 0; k < 95; k++) begin
        // Reports mostly follow the phase climate, with a few wild readings.
        r = $urandom_range(0, 99);
        w.slot        = 1'($urandom_range(0, 1));
        w.temperature = TEMP_W'($urandom);
        if (r < 26) begin
          w.func = FUNC_REPORT;
          if ($urandom_range(0, 11) != 0)
            w.temperature = TEMP_W'((w.slot ? base_out : base_in) +
                                    int'($urandom_range(0, 2 * spread)) - spread);
        end else if (r < 56) begin
          w.func = FUNC_SAMPLE;
        end else if (r < 96) begin
          w.func = FUNC_TICK;
        end else begin
          w.func = FUNC_TEST;
        end
        send_word(w);
        if ($urandom_range(0, 99) == 0) drain_results();
      end
    end

    drain_results();
    repeat (40) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("ventilation_gradient_alarm_unit verification clean");
    end else begin
      $display("ventilation_gradient_alarm_unit verification failed");
    end
    $finish;
  end

  // Hard stop in case the handshake hangs.
  initial begin
    #(RUN_LIMIT);
    $display("ventilation_gradient_alarm_unit verification failed");
    $finish;
  end

endmodule

// File: filelist.f
rtl/core/vgalarm_pkg.sv
rtl/core/ventilation_gradient_alarm_unit.sv
rtl/core/vgalarm_checker.sv
sim/ventilation_gradient_alarm_checker.sv
sim/ventilation_gradient_alarm_unit_tb.sv
